// File: sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication with the consequent checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/mstk_pkg.sv
// shared types and constants of the spanning tree block
package mstk_pkg;
  localparam int MaxNodes  = 64;
  localparam int MaxEdges  = 2048;
  localparam int CountBits = 16;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int AddrW     = $clog2(MaxEdges);
  localparam int FillW     = AddrW + 1;
  localparam int EdgeW     = 2 * NodeW + CountBits;

  localparam logic [0:0] CfgNodeCount  = 1'b0;
  localparam logic [0:0] CfgMinMatches = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // write the input edge if it passes the filter
    logic scan_start; // begin a max search over untaken edges
    logic scan_step;  // advance the search by one entry
    logic mark_best;  // set taken bit of best
    logic forest_clr; // reset one forest node and the tree size (sweep step)
    logic find_step;  // one hop of the root walk
    logic find_init;  // start the root walks from best endpoints
    logic merge;      // link roots and count
    logic run_done;   // empty the store
  } mstk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;   // search passed the fill count
    logic have;       // search found an entry
    logic roots_done; // both walks reached their roots
    logic differ;     // roots differ
    logic tree_full;  // limit reached
    logic clr_end;    // clear sweep finished
  } mstk_sts_t;
endpackage

// File: sv/max_spanning_tree_kruskal.sv
// top level: maximum spanning forest over loaded edges
// load: one edge item per cycle, in_stall low while loading
// run after the last edge: a forest clear sweep, then per pick one scan over
// the edge memory read port, plus root walks of up to 63 hops
// each tree edge is shown once the next merging pick is found or the run ends
// reset (rst_n low, synchronous): empty store, node_count 64, min_matches 0
`include "assert_macros.svh"
module max_spanning_tree_kruskal import mstk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [NodeW-1:0]     in_node_a,
  input  logic [NodeW-1:0]     in_node_b,
  input  logic [CountBits-1:0] in_match_count,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [NodeW-1:0]     out_tree_a,
  output logic [NodeW-1:0]     out_tree_b,
  output logic [CountBits-1:0] out_tree_matches,
  output logic                 out_none_found,
  output logic                 out_final_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  mstk_cmd_t cmd;
  mstk_sts_t sts;
  logic [6:0]  node_count_r;
  logic [15:0] min_matches_r;
  logic [NodeW-1:0] ba, bb;
  logic [CountBits-1:0] bc;
  logic acc;

  assign cfg_ready = 1'b1;
  assign acc = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'(MaxNodes); min_matches_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgNodeCount:  node_count_r  <= cfg_data[6:0];
        CfgMinMatches: min_matches_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mstk_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(acc), .in_stall, .in_last, .cmd, .sts,
    .best_a(ba), .best_b(bb), .best_cnt(bc),
    .out_valid, .out_stall, .out_a(out_tree_a), .out_b(out_tree_b),
    .out_cnt(out_tree_matches), .out_none(out_none_found), .out_final(out_final_res)
  );

  mstk_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .node_count(node_count_r),
    .min_matches(min_matches_r), .in_a(in_node_a), .in_b(in_node_b),
    .in_cnt(in_match_count), .best_a(ba), .best_b(bb), .best_cnt(bc)
  );

  `ASSERT_IMPL(a_load_only_idle, clk, rst_n, cmd.load, !in_stall)
  `ASSERT_IMPL(a_out_zero_none, clk, rst_n, out_valid && out_none_found,
    out_tree_matches == '0)
endmodule

// File: sv/mstk_datapath.sv
// edge store, taken bits, forest and search registers
`include "assert_macros.svh"
module mstk_datapath import mstk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mstk_cmd_t            cmd,
  output mstk_sts_t            sts,
  input  logic [6:0]           node_count,
  input  logic [15:0]          min_matches,
  input  logic [NodeW-1:0]     in_a,
  input  logic [NodeW-1:0]     in_b,
  input  logic [CountBits-1:0] in_cnt,
  output logic [NodeW-1:0]     best_a,
  output logic [NodeW-1:0]     best_b,
  output logic [CountBits-1:0] best_cnt
);
  logic [EdgeW-1:0]     store [MaxEdges];
  logic                 taken_bits [MaxEdges];
  logic [EdgeW-1:0]     rd_data_r;
  logic                 rd_taken_r;
  logic [NodeW-1:0]     parent_r [MaxNodes];
  logic [FillW-1:0]     fill_r;
  logic [FillW-1:0]     ptr_r;      // address issued to memory
  logic [FillW-1:0]     rd_idx_r;   // address of rd_data_r
  logic                 rd_vld_r;
  logic [AddrW-1:0]     best_idx_r;
  logic [CountBits-1:0] best_cnt_r;
  logic                 have_r;
  logic [NodeW-1:0]     ba_r, bb_r, ra_r, rb_r;
  logic [NodeW-1:0]     pa_r, pb_r;     // parents of ra_r and rb_r
  logic [NodeW-1:0]     ra_nxt, rb_nxt;
  logic [NodeW:0]       size_r;
  logic [NodeW:0]       clr_r;
  logic [6:0]           eff_n;
  logic [NodeW:0]       limit;
  logic                 pass;
  logic [CountBits-1:0] rd_cnt;
  logic                 tk_we;
  logic [AddrW-1:0]     tk_addr;

  assign eff_n = (node_count > 7'(MaxNodes)) ? 7'(MaxNodes) : node_count;
  assign limit = (eff_n == 7'd0) ? '0 : (NodeW+1)'(eff_n - 7'd1);
  assign pass  = (in_cnt >= min_matches[CountBits-1:0]) &&
                 (7'(in_a) < eff_n) && (7'(in_b) < eff_n) &&
                 (fill_r < FillW'(MaxEdges));
  assign rd_cnt = rd_data_r[CountBits-1:0];

  // taken bit of an entry is cleared when the edge loads, set when picked
  assign tk_we   = (cmd.load && pass) || cmd.mark_best;
  assign tk_addr = cmd.mark_best ? best_idx_r : fill_r[AddrW-1:0];

  assign ra_nxt = cmd.find_init ? ba_r : (cmd.find_step ? pa_r : ra_r);
  assign rb_nxt = cmd.find_init ? bb_r : (cmd.find_step ? pb_r : rb_r);

  always_ff @(posedge clk) begin
    if (cmd.load && pass) store[fill_r[AddrW-1:0]] <= {in_a, in_b, in_cnt};
    rd_data_r <= store[ptr_r[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tk_we) taken_bits[tk_addr] <= cmd.mark_best;
    rd_taken_r <= taken_bits[ptr_r[AddrW-1:0]];
  end

  // forest: one node per cycle in the clear sweep, registered parent reads
  always_ff @(posedge clk) begin
    if (cmd.forest_clr) parent_r[clr_r[NodeW-1:0]] <= clr_r[NodeW-1:0];
    if (cmd.merge) parent_r[ra_r] <= rb_r;
    pa_r <= parent_r[ra_nxt];
    pb_r <= parent_r[rb_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0; ptr_r <= '0; rd_idx_r <= '0; rd_vld_r <= 1'b0;
      have_r <= 1'b0; size_r <= '0; clr_r <= '0;
      best_idx_r <= '0; best_cnt_r <= '0;
      ba_r <= '0; bb_r <= '0; ra_r <= '0; rb_r <= '0;
    end else begin
      if (cmd.load && pass) fill_r <= fill_r + 1'b1;
      if (cmd.forest_clr) begin
        size_r  <= '0;
        clr_r   <= clr_r + 1'b1;
      end
      if (cmd.scan_start) begin
        ptr_r <= '0; rd_vld_r <= 1'b0; have_r <= 1'b0; clr_r <= '0;
      end
      if (cmd.scan_step) begin
        ptr_r    <= ptr_r + 1'b1;
        rd_idx_r <= ptr_r;
        rd_vld_r <= (ptr_r < fill_r);
        if (rd_vld_r && !rd_taken_r &&
            (!have_r || rd_cnt > best_cnt_r)) begin
          have_r     <= 1'b1;
          best_idx_r <= rd_idx_r[AddrW-1:0];
          best_cnt_r <= rd_cnt;
          ba_r <= rd_data_r[EdgeW-1 -: NodeW];
          bb_r <= rd_data_r[CountBits +: NodeW];
        end
      end
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
      if (cmd.merge) size_r <= size_r + 1'b1;
      if (cmd.run_done) fill_r <= '0;
    end
  end

  assign sts.scan_end   = rd_vld_r == 1'b0 && ptr_r != '0 && ptr_r > fill_r;
  assign sts.have       = have_r;
  assign sts.roots_done = (pa_r == ra_r) && (pb_r == rb_r);
  assign sts.differ     = ra_r != rb_r;
  assign sts.tree_full  = size_r >= limit;
  assign sts.clr_end    = clr_r == (NodeW+1)'(MaxNodes);
  assign best_a   = ba_r;
  assign best_b   = bb_r;
  assign best_cnt = best_cnt_r;

  `ASSERT_IMPL(a_fill_max, clk, rst_n, 1'b1, fill_r <= FillW'(MaxEdges))
  `ASSERT_NEXT(a_merge_cnt, clk, rst_n, cmd.merge, size_r == $past(size_r) + 1'b1)
  `ASSERT_IMPL(a_merge_roots, clk, rst_n, cmd.merge, ra_r != rb_r)
endmodule

// File: sv/mstk_ctrl.sv
// run sequencer and result register
`include "assert_macros.svh"
module mstk_ctrl import mstk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_last,
  output mstk_cmd_t            cmd,
  input  mstk_sts_t            sts,
  input  logic [NodeW-1:0]     best_a,
  input  logic [NodeW-1:0]     best_b,
  input  logic [CountBits-1:0] best_cnt,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [NodeW-1:0]     out_a,
  output logic [NodeW-1:0]     out_b,
  output logic [CountBits-1:0] out_cnt,
  output logic                 out_none,
  output logic                 out_final
);
  typedef enum logic [2:0] {S_LOAD, S_CLR, S_SCAN, S_PICK, S_FIND, S_EMIT, S_END}
    state_t;
  state_t state_r, state_nxt;
  logic   took_r, took_nxt;
  logic   ov_r, ov_nxt;
  logic [NodeW-1:0]     oa_r, oa_nxt, ob_r, ob_nxt;
  logic [CountBits-1:0] oc_r, oc_nxt;
  logic   on_r, on_nxt, of_r, of_nxt;
  logic   out_acc;
  logic   free;

  // a held back edge stays in the register until it is shown and taken
  assign out_acc  = out_valid && !out_stall;
  assign free     = !ov_r || out_acc;
  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    cmd = '0;
    state_nxt = state_r; took_nxt = took_r;
    ov_nxt = ov_r && !out_acc;
    oa_nxt = oa_r; ob_nxt = ob_r; oc_nxt = oc_r; on_nxt = on_r; of_nxt = of_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.scan_start = 1'b1;
            took_nxt = 1'b0;
            state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.forest_clr = !sts.clr_end;
        if (sts.clr_end) begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.tree_full) state_nxt = S_END;
        else if (sts.scan_end) state_nxt = sts.have ? S_PICK : S_END;
        else cmd.scan_step = 1'b1;
      end
      S_PICK: begin
        cmd.mark_best = 1'b1;
        cmd.find_init = 1'b1;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        if (!sts.roots_done) cmd.find_step = 1'b1;
        else if (!sts.differ) begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end else state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold each edge until the output register frees, final set at end
        if (free) begin
          cmd.merge = 1'b1;
          cmd.scan_start = 1'b1;
          ov_nxt = 1'b1; oa_nxt = best_a; ob_nxt = best_b; oc_nxt = best_cnt;
          on_nxt = 1'b0; of_nxt = 1'b0;
          took_nxt = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_END: begin
        if (took_r) begin
          // mark the already emitted edge as last: it still waits in the register,
          // since held back emits keep it from being taken before now
          of_nxt = 1'b1;
          cmd.run_done = 1'b1;
          state_nxt = S_LOAD;
        end else if (free) begin
          ov_nxt = 1'b1; oa_nxt = '0; ob_nxt = '0; oc_nxt = '0;
          on_nxt = 1'b1; of_nxt = 1'b1;
          cmd.run_done = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // a taken edge is shown only after the next decision, so final can be set
  // on the register: out_valid is withheld while the run is still searching
  logic shown_r, shown_nxt;
  always_comb begin
    shown_nxt = shown_r;
    if (state_r == S_EMIT && free) shown_nxt = 1'b0;
    else if ((state_r == S_FIND && sts.roots_done && sts.differ) ||
             state_r == S_END) shown_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; took_r <= 1'b0; ov_r <= 1'b0; shown_r <= 1'b1;
    end else begin
      state_r <= state_nxt; took_r <= took_nxt; ov_r <= ov_nxt; shown_r <= shown_nxt;
    end
    oa_r <= oa_nxt; ob_r <= ob_nxt; oc_r <= oc_nxt; on_r <= on_nxt; of_r <= of_nxt;
  end

  assign out_valid = ov_r && shown_r;
  assign out_a = oa_r;
  assign out_b = ob_r;
  assign out_cnt = oc_r;
  assign out_none = on_r;
  assign out_final = of_r;

  `ASSERT_IMPL(a_no_load_busy, clk, rst_n, state_r != S_LOAD, in_stall)
  `ASSERT_IMPL(a_none_final, clk, rst_n, out_valid && out_none, out_final)
  `ASSERT_NEXT(a_end_load, clk, rst_n, state_r == S_END && took_r, state_r == S_LOAD)
endmodule

// File: bench/max_spanning_tree_kruskal_tb.sv
// testbench for the maximum spanning forest block: directed and random edge sets
`timescale 1ns / 100ps
module max_spanning_tree_kruskal_tb;
  import mstk_pkg::*;

  localparam int CycleLimit = 4000000;

  typedef struct {
    logic [NodeW-1:0]     a;
    logic [NodeW-1:0]     b;
    logic [CountBits-1:0] cnt;
  } edge_rec_t;

  typedef struct {
    logic [NodeW-1:0]     tree_a;
    logic [NodeW-1:0]     tree_b;
    logic [CountBits-1:0] tree_matches;
    logic                 none_found;
    logic                 final_res;
  } tree_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [NodeW-1:0] in_node_a;
  logic [NodeW-1:0] in_node_b;
  logic [CountBits-1:0] in_match_count;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic [NodeW-1:0] out_tree_a;
  logic [NodeW-1:0] out_tree_b;
  logic [CountBits-1:0] out_tree_matches;
  logic out_none_found;
  logic out_final_res;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [15:0] cfg_data;

  // predictor state
  edge_rec_t kept_edges[$];
  tree_res_t tree_due[$];
  logic [6:0] node_count_q;
  logic [15:0] min_matches_q;

  int errors;
  int cycles;
  bit quiet;      // no gaps on either side
  bit hold_long;  // receiver holds off for a long stretch

  max_spanning_tree_kruskal DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: random stalls, plus a long hold when asked
  initial begin
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_long = 1'b0;
      end else begin
        out_stall <= (!quiet && $urandom_range(0, 9) > 6);
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // ---- predictor ----

  function automatic int root_of(ref logic [NodeW-1:0] parent[MaxNodes], input int x);
    int hops;
    hops = 0;
    while (parent[x] != x && hops < MaxNodes) begin
      x = parent[x];
      hops++;
    end
    return x;
  endfunction

  // kruskal over the kept edges: heaviest first, ties in load order
  function automatic void build_forest();
    logic [NodeW-1:0] parent[MaxNodes];
    bit taken[];
    int n, limit, picked, best, ra, rb;
    tree_res_t res;
    n = (node_count_q > MaxNodes) ? MaxNodes : node_count_q;
    limit = (n > 0) ? n - 1 : 0;
    picked = 0;
    taken = new[kept_edges.size()];
    for (int i = 0; i < MaxNodes; i++) parent[i] = NodeW'(i);
    while (picked < limit) begin
      best = -1;
      foreach (kept_edges[i]) begin
        if (!taken[i] && (best < 0 || kept_edges[i].cnt > kept_edges[best].cnt)) best = i;
      end
      if (best < 0) break;
      taken[best] = 1'b1;
      ra = root_of(parent, kept_edges[best].a);
      rb = root_of(parent, kept_edges[best].b);
      if (ra != rb) begin
        parent[ra] = NodeW'(rb);
        res.tree_a = kept_edges[best].a;
        res.tree_b = kept_edges[best].b;
        res.tree_matches = kept_edges[best].cnt;
        res.none_found = 1'b0;
        res.final_res = 1'b0;
        tree_due = {tree_due, res};
        picked++;
      end
    end
    if (picked == 0) begin
      res = '{'0, '0, '0, 1'b1, 1'b1};
      tree_due = {tree_due, res};
    end else begin
      tree_due[tree_due.size() - 1].final_res = 1'b1;
    end
    kept_edges.delete();
  endfunction

  function automatic void predict_edge(logic [NodeW-1:0] a, logic [NodeW-1:0] b,
                                       logic [CountBits-1:0] cnt, logic last);
    int n;
    edge_rec_t rec;
    n = (node_count_q > MaxNodes) ? MaxNodes : node_count_q;
    if (cnt >= min_matches_q && a < n && b < n && kept_edges.size() < MaxEdges) begin
      rec = '{a, b, cnt};
      kept_edges = {kept_edges, rec};
    end
    if (last) build_forest();
  endfunction

  // ---- result checker ----
  always @(posedge clk) begin
    tree_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (tree_due.size() == 0) begin
        $display("%0t: unexpected item a=%0d b=%0d m=%0d", $time, out_tree_a,
                 out_tree_b, out_tree_matches);
        errors++;
      end else begin
        exp_r = tree_due.pop_front();
        if (out_tree_a !== exp_r.tree_a) begin
          $display("%0t: tree_a exp %0d got %0d", $time, exp_r.tree_a, out_tree_a);
          errors++;
        end
        if (out_tree_b !== exp_r.tree_b) begin
          $display("%0t: tree_b exp %0d got %0d", $time, exp_r.tree_b, out_tree_b);
          errors++;
        end
        if (out_tree_matches !== exp_r.tree_matches) begin
          $display("%0t: tree_matches exp %0d got %0d", $time, exp_r.tree_matches,
                   out_tree_matches);
          errors++;
        end
        if (out_none_found !== exp_r.none_found) begin
          $display("%0t: none_found exp %0b got %0b", $time, exp_r.none_found,
                   out_none_found);
          errors++;
        end
        if (out_final_res !== exp_r.final_res) begin
          $display("%0t: final_res exp %0b got %0b", $time, exp_r.final_res,
                   out_final_res);
          errors++;
        end
      end
    end
  end

  // ---- drivers ----

  // offer one edge item, hold it until accepted
  task automatic send_edge(logic [NodeW-1:0] a, logic [NodeW-1:0] b,
                           logic [CountBits-1:0] cnt, logic last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_node_a <= a;
    in_node_b <= b;
    in_match_count <= cnt;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    predict_edge(a, b, cnt, last);
  endtask

  // sender pauses until every tree edge has come, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tree_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgNodeCount) node_count_q = data[6:0];
    else min_matches_q = data;
  endtask

  // random set over nodes below span, some edges outside it
  task automatic send_random_set(int span, int len);
    logic [NodeW-1:0] a, b;
    logic [CountBits-1:0] cnt;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = NodeW'($urandom);
        b = NodeW'($urandom);
      end else begin
        a = NodeW'($urandom_range(0, span - 1));
        b = NodeW'($urandom_range(0, span - 1));
      end
      case ($urandom_range(0, 3))
        0: cnt = CountBits'($urandom);
        1: cnt = CountBits'($urandom_range(0, 7));       // many ties
        2: cnt = CountBits'(16'hffff - $urandom_range(0, 3));
        default: cnt = CountBits'($urandom_range(0, 400));
      endcase
      send_edge(a, b, cnt, i == len - 1);
    end
  endtask

  // ---- tests ----

  task automatic test_extremes();
    write_reg(CfgNodeCount, 64);
    write_reg(CfgMinMatches, 0);
    send_edge(0, 63, 16'hffff, 0);
    send_edge(63, 0, 0, 0);
    send_edge(5, 5, 100, 0);         // self loop never merges
    send_edge(1, 2, 16'hffff, 0);    // tie with the first edge
    send_edge(42, 21, 16'h5555, 0);
    send_edge(21, 42, 16'haaaa, 0);
    send_edge(2, 3, 1, 1);
  endtask

  task automatic test_weight_filter();
    write_reg(CfgMinMatches, 16'hffff);
    send_edge(0, 1, 16'hfffe, 0);    // dropped
    send_edge(2, 3, 16'hffff, 1);
    write_reg(CfgMinMatches, 300);
    send_edge(0, 1, 299, 0);
    send_edge(1, 0, 300, 1);
    write_reg(CfgMinMatches, 0);
  endtask

  task automatic test_node_range();
    write_reg(CfgNodeCount, 3);
    send_edge(0, 3, 50, 0);          // index at node count, dropped
    send_edge(63, 1, 60, 0);
    send_edge(0, 1, 10, 0);
    send_edge(1, 2, 10, 0);
    send_edge(0, 2, 20, 1);
  endtask

  task automatic test_empty_runs();
    write_reg(CfgNodeCount, 0);      // everything dropped
    send_edge(0, 1, 9, 1);
    write_reg(CfgNodeCount, 1);      // no edge can be taken
    send_edge(0, 0, 9, 1);
    write_reg(CfgNodeCount, 8);
    send_edge(4, 4, 77, 1);          // lone self loop
  endtask

  task automatic test_node_count_clamp();
    write_reg(CfgNodeCount, 127);
    send_random_set(64, 20);
    write_reg(CfgNodeCount, 100);
    send_random_set(64, 12);
  endtask

  // receiver holds off while two sets are offered back to back
  task automatic test_backpressure();
    write_reg(CfgNodeCount, 16);
    hold_long = 1'b1;
    send_random_set(16, 14);
    send_random_set(16, 10);
    drain();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 355) begin
      int span, len;
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CfgNodeCount, $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 127)) :
                  16'($urandom_range(2, 12)));
        write_reg(CfgMinMatches, $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'd0);
      end
      span = (node_count_q == 0) ? 1 : (node_count_q > 64 ? 64 : node_count_q);
      len = $urandom_range(1, 20);
      quiet = ($urandom_range(0, 5) == 0);
      send_random_set(span, len);
      sent += len;
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_long = 1'b0;
    node_count_q = 64;
    min_matches_q = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_node_a <= '0;
    in_node_b <= '0;
    in_match_count <= '0;
    in_last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CfgNodeCount;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_weight_filter();
    test_node_range();
    test_empty_runs();
    test_node_count_clamp();
    test_backpressure();
    test_random();

    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/mstk_pkg.sv
sv/mstk_datapath.sv
sv/mstk_ctrl.sv
sv/max_spanning_tree_kruskal.sv
bench/max_spanning_tree_kruskal_tb.sv
